// ----- hdl/vram_rect_blit_engine_assert.svh -----
// Assertion macros for the rectangle blit engine checker.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef VRAM_RECT_BLIT_ENGINE_ASSERT_SVH
`define VRAM_RECT_BLIT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VRBE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VRBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/vrbe_pkg.sv -----
// Shared types and codes for the rectangle blit engine.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package vrbe_pkg;

   // Field widths of the request and response items
   localparam int MODE_W = 3;
   localparam int X_W    = 10;
   localparam int Y_W    = 9;
   localparam int WID_W  = 11;
   localparam int HGT_W  = 10;
   localparam int PIX_W  = 16;
   localparam int STAT_W = 2;

   // Width of a coordinate plus an extent, compared against the memory size
   localparam int FIT_W  = 13;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_FILL     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_START = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WR_PIXEL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RD_START = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RD_PIXEL = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MOVE     = 3'd5;

   // Response status codes
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BOUNDS  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NO_XFER = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [X_W-1:0]    dest_x;
      logic [Y_W-1:0]    dest_y;
      logic [WID_W-1:0]  rect_width;
      logic [HGT_W-1:0]  rect_height;
      logic [X_W-1:0]    src_x;
      logic [Y_W-1:0]    src_y;
      logic [PIX_W-1:0]  pixel;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0]  read_value;
      logic [STAT_W-1:0] status;
      logic              transfer_last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_WRITE,
      KIND_READ
   } xfer_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_READ_WAIT,
      ST_POST
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/vram_rect_blit_engine.sv -----
// Rectangle fill, move and pixel transfer engine over a 16-bit video memory.
// Depends on vrbe_pkg for the item structs, mode and status codes and states.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  req      | in        | req_valid / req_stall      | req_data (req_item_type)
//  rsp      | out       | rsp_valid / rsp_stall      | rsp_data (rsp_item_type)
//
// Start, write pixel, error and unused-mode items are answered when accepted, or from
// the post state while an older response is stalled; read pixel waits in a read-wait
// state for the registered read data of the single video memory. Fill makes one write
// (move: a read, then a write) per pixel, then the post state answers. After reset a clearing
// pass writes zero to all MEM_ROWS << clog2(columns) entries (524288 by default) and
// takes no request transfer. A stalled response is held while the next request runs.
`default_nettype none

module vram_rect_blit_engine #(
   parameter int MEM_COLUMNS = 1024,
   parameter int MEM_ROWS    = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vrbe_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vrbe_pkg::rsp_item_type rsp_data
);
   import vrbe_pkg::*;

   localparam int COL_W  = $clog2(MEM_COLUMNS);
   localparam int ROW_W  = $clog2(MEM_ROWS);
   localparam int YB_W   = ROW_W + 1;
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DEPTH  = MEM_ROWS << COL_W;
   localparam logic [FIT_W-1:0] COL_LIM = FIT_W'(MEM_COLUMNS);
   localparam logic [FIT_W-1:0] ROW_LIM = FIT_W'(MEM_ROWS);

   // Control state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;

   // Video memory and its registered read data
   logic [PIX_W-1:0]    vram_mem_ff [DEPTH];
   logic [PIX_W-1:0]    mem_rd_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   logic [ADDR_W-1:0]   mem_ra;
   logic [PIX_W-1:0]    mem_wd;

   // Rectangle walk for fill and move
   logic [COL_W-1:0]    dst_x_ff, dst_x_in;
   logic [ROW_W-1:0]    dst_y_ff, dst_y_in;
   logic [COL_W-1:0]    src_x_ff, src_x_in;
   logic [ROW_W-1:0]    src_y_ff, src_y_in;
   logic [WID_W-1:0]    wid_ff, wid_in;
   logic [HGT_W-1:0]    hgt_ff, hgt_in;
   logic [WID_W-1:0]    col_ff, col_in;
   logic [HGT_W-1:0]    row_ff, row_in;
   logic [PIX_W-1:0]    fill_pix_ff, fill_pix_in;

   // Open pixel transfer
   xfer_kind_type       kind_ff, kind_in;
   logic [COL_W-1:0]    left_ff, left_in;
   logic [WID_W-1:0]    xwid_ff, xwid_in;
   logic [YB_W-1:0]     bottom_ff, bottom_in;
   logic [WID_W-1:0]    cur_x_ff, cur_x_in;
   logic [YB_W-1:0]     cur_y_ff, cur_y_in;

   // Response path
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;
   rsp_item_type        res_ff, res_in;

   // Combinational helpers
   logic                req_xfer;
   logic                out_free;
   logic                clr_done;
   logic [FIT_W-1:0]    dst_col_sum, dst_row_sum, src_col_sum, src_row_sum, xfer_col_sum;
   logic [FIT_W-1:0]    req_dst_cols, req_dst_rows, req_src_cols, req_src_rows;
   logic [ADDR_W-1:0]   dst_addr, src_addr, xfer_addr;
   logic                col_last, row_last, walk_done;
   logic [WID_W-1:0]    cx_next;
   logic [YB_W-1:0]     cy_next;
   logic                cx_wrap, y_end, xfer_end;
   logic                dst_fit, src_fit, rect_empty;
   logic                go_fill, go_move, go_read;
   rsp_item_type        imm_rsp;

   // Handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign clr_done  = (clr_ff == ADDR_W'(DEPTH - 1));

   // Form memory addresses: row bits above a power-of-two column field
   assign dst_col_sum  = FIT_W'(dst_x_ff) + FIT_W'(col_ff);
   assign dst_row_sum  = FIT_W'(dst_y_ff) + FIT_W'(row_ff);
   assign src_col_sum  = FIT_W'(src_x_ff) + FIT_W'(col_ff);
   assign src_row_sum  = FIT_W'(src_y_ff) + FIT_W'(row_ff);
   assign xfer_col_sum = FIT_W'(left_ff) + FIT_W'(cur_x_ff);
   assign dst_addr  = {dst_row_sum[ROW_W-1:0], dst_col_sum[COL_W-1:0]};
   assign src_addr  = {src_row_sum[ROW_W-1:0], src_col_sum[COL_W-1:0]};
   assign xfer_addr = {cur_y_ff[ROW_W-1:0], xfer_col_sum[COL_W-1:0]};

   // Walk position
   assign col_last  = (col_ff == wid_ff - WID_W'(1));
   assign row_last  = (row_ff == hgt_ff - HGT_W'(1));
   assign walk_done = col_last && row_last;

   // Transfer cursor advance
   assign cx_next  = cur_x_ff + WID_W'(1);
   assign cy_next  = cur_y_ff + YB_W'(1);
   assign cx_wrap  = (cx_next >= xwid_ff);
   assign y_end    = (cy_next >= bottom_ff);
   assign xfer_end = cx_wrap && y_end;

   // Check request rectangles against the memory size
   assign req_dst_cols = FIT_W'(req_data.dest_x) + FIT_W'(req_data.rect_width);
   assign req_dst_rows = FIT_W'(req_data.dest_y) + FIT_W'(req_data.rect_height);
   assign req_src_cols = FIT_W'(req_data.src_x) + FIT_W'(req_data.rect_width);
   assign req_src_rows = FIT_W'(req_data.src_y) + FIT_W'(req_data.rect_height);
   assign dst_fit    = (req_dst_cols <= COL_LIM) && (req_dst_rows <= ROW_LIM);
   assign src_fit    = (req_src_cols <= COL_LIM) && (req_src_rows <= ROW_LIM);
   assign rect_empty = (req_data.rect_width == '0) || (req_data.rect_height == '0);

   // Decode the request into its immediate response and its follow-up work
   always_comb begin
      imm_rsp = '0;
      go_fill = 1'b0;
      go_move = 1'b0;
      go_read = 1'b0;
      unique case (req_data.mode) inside
         MODE_FILL: begin
            imm_rsp.status = dst_fit ? STATUS_OK : STATUS_BOUNDS;
            go_fill        = dst_fit && !rect_empty;
         end
         MODE_WR_START, MODE_RD_START: begin
            imm_rsp.status = dst_fit ? STATUS_OK : STATUS_BOUNDS;
         end
         MODE_WR_PIXEL: begin
            if (kind_ff != KIND_WRITE) begin
               imm_rsp.status = STATUS_NO_XFER;
            end else begin
               imm_rsp.transfer_last = xfer_end;
            end
         end
         MODE_RD_PIXEL: begin
            if (kind_ff != KIND_READ) begin
               imm_rsp.status = STATUS_NO_XFER;
            end else begin
               imm_rsp.transfer_last = xfer_end;
               go_read               = 1'b1;
            end
         end
         MODE_MOVE: begin
            imm_rsp.status = (dst_fit && src_fit) ? STATUS_OK : STATUS_BOUNDS;
            go_move        = dst_fit && src_fit && !rect_empty;
         end
         default: begin
            imm_rsp.status = STATUS_OK;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (go_fill) begin
                  state_in = ST_FILL;
               end else if (go_move) begin
                  state_in = ST_MOVE_RD;
               end else if (go_read) begin
                  state_in = ST_READ_WAIT;
               end else if (!out_free) begin
                  state_in = ST_POST;
               end
            end
         end
         ST_FILL: begin
            if (walk_done) begin
               state_in = ST_POST;
            end
         end
         ST_MOVE_RD: begin
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            state_in = walk_done ? ST_POST : ST_MOVE_RD;
         end
         ST_READ_WAIT: begin
            state_in = out_free ? ST_IDLE : ST_POST;
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory control and response
   always_comb begin
      clr_in       = clr_ff;
      dst_x_in     = dst_x_ff;
      dst_y_in     = dst_y_ff;
      src_x_in     = src_x_ff;
      src_y_in     = src_y_ff;
      wid_in       = wid_ff;
      hgt_in       = hgt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fill_pix_in  = fill_pix_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      xwid_in      = xwid_ff;
      bottom_in    = bottom_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_wa       = dst_addr;
      mem_wd       = fill_pix_ff;
      mem_ra       = src_addr;

      // Drop the response once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               // Latch the walk setup; only fill and move use it
               dst_x_in    = COL_W'(req_data.dest_x);
               dst_y_in    = ROW_W'(req_data.dest_y);
               src_x_in    = COL_W'(req_data.src_x);
               src_y_in    = ROW_W'(req_data.src_y);
               wid_in      = req_data.rect_width;
               hgt_in      = req_data.rect_height;
               col_in      = '0;
               row_in      = '0;
               fill_pix_in = req_data.pixel;
               res_in      = imm_rsp;

               unique case (req_data.mode) inside
                  MODE_WR_START, MODE_RD_START: begin
                     kind_in = KIND_NONE;
                     if (dst_fit && !rect_empty) begin
                        left_in   = COL_W'(req_data.dest_x);
                        xwid_in   = req_data.rect_width;
                        bottom_in = YB_W'(req_dst_rows);
                        cur_x_in  = '0;
                        cur_y_in  = YB_W'(req_data.dest_y);
                        kind_in   = (req_data.mode == MODE_WR_START) ? KIND_WRITE : KIND_READ;
                     end
                  end
                  MODE_WR_PIXEL: begin
                     if (kind_ff == KIND_WRITE) begin
                        mem_we = 1'b1;
                        mem_wa = xfer_addr;
                        mem_wd = req_data.pixel;
                        if (cx_wrap) begin
                           cur_x_in = '0;
                           cur_y_in = cy_next;
                           if (y_end) begin
                              kind_in = KIND_NONE;
                           end
                        end else begin
                           cur_x_in = cx_next;
                        end
                     end
                  end
                  MODE_RD_PIXEL: begin
                     if (kind_ff == KIND_READ) begin
                        mem_ra = xfer_addr;
                        if (cx_wrap) begin
                           cur_x_in = '0;
                           cur_y_in = cy_next;
                           if (y_end) begin
                              kind_in = KIND_NONE;
                           end
                        end else begin
                           cur_x_in = cx_next;
                        end
                     end
                  end
                  default: begin
                  end
               endcase

               // Answer at once when nothing more is to be done
               if (!go_fill && !go_move && !go_read && out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = imm_rsp;
               end
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + HGT_W'(1);
            end else begin
               col_in = col_ff + WID_W'(1);
            end
         end
         ST_MOVE_RD: begin
            mem_ra = src_addr;
         end
         ST_MOVE_WR: begin
            mem_we = 1'b1;
            mem_wd = mem_rd_ff;
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + HGT_W'(1);
            end else begin
               col_in = col_ff + WID_W'(1);
            end
         end
         ST_READ_WAIT: begin
            res_in.read_value = mem_rd_ff;
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = res_ff;
               rsp_data_in.read_value = mem_rd_ff;
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Video memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram_mem_ff[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= vram_mem_ff[mem_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         kind_ff      <= KIND_NONE;
         left_ff      <= '0;
         xwid_ff      <= '0;
         bottom_ff    <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         xwid_ff      <= xwid_in;
         bottom_ff    <= bottom_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dst_x_ff    <= dst_x_in;
      dst_y_ff    <= dst_y_in;
      src_x_ff    <= src_x_in;
      src_y_ff    <= src_y_in;
      wid_ff      <= wid_in;
      hgt_ff      <= hgt_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      fill_pix_ff <= fill_pix_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- hdl/vrbe_checker.sv -----
// Port-level checker for the rectangle blit engine, bound to the top level.
// Depends on vrbe_pkg and on the macros in vram_rect_blit_engine_assert.svh.
`default_nettype none

`include "vram_rect_blit_engine_assert.svh"

module vrbe_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input vrbe_pkg::rsp_item_type rsp_data
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [2:0] pending_ff, pending_in;

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 3'(req_xfer) - 3'(rsp_xfer);

   // Count requests whose response transfer is still owed
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `VRBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
   `VRBE_ASSERT_IMPLY(a_clear_blocks, clock, reset, $past(reset) && !reset, req_stall, "request taken during clearing pass")
   `VRBE_ASSERT_IMPLY(a_rsp_owed, clock, reset, rsp_valid, pending_ff != 3'd0, "response without a request")
   `VRBE_ASSERT_IMPLY(a_pending_cap, clock, reset, 1'b1, pending_ff <= 3'd2, "more than two requests in flight")

endmodule

bind vram_rect_blit_engine vrbe_checker u_vrbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
